// ----- src/swk_pkg.sv -----
// swk_pkg: shared types, constants and helper functions of the swerve wheel kinematics block
// no dependencies; used by the channel interfaces, swk_cordic and swerve_wheel_kinematics_top
package swk_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;

    // angles in 1/16 degree
    localparam logic [12:0] FULL_TURN    = 13'd5760;
    localparam logic [12:0] HALF_TURN    = 13'd2880;
    localparam logic [12:0] QUARTER_TURN = 13'd1440;
    localparam logic [12:0] ZERO_STEER   = 13'd4320;

    // cordic gain prescale, q1.30
    localparam logic [29:0] CORDIC_K = 30'd652032874;
    // 180 degrees in the internal q.16 degree format
    localparam int          HALF_TURN_Z = 11796480;
    localparam int          ZW          = 27;

    // configuration register indexes
    localparam int          CFG_IDX_W    = 3;
    localparam logic [2:0]  CFG_RADIUS   = 3'd0;
    localparam logic [2:0]  CFG_MOUNT_FL = 3'd1;
    localparam logic [2:0]  CFG_MOUNT_RL = 3'd2;
    localparam logic [2:0]  CFG_MOUNT_FR = 3'd3;
    localparam logic [2:0]  CFG_MOUNT_RR = 3'd4;

    typedef struct packed {
        logic [15:0]        travel_speed;
        logic [12:0]        travel_heading;
        logic signed [15:0] rotation_rate;
        logic [12:0]        robot_facing;
    } t_cmd;

    typedef struct packed {
        logic [15:0] front_left_speed;
        logic [15:0] rear_left_speed;
        logic [15:0] front_right_speed;
        logic [15:0] rear_right_speed;
        logic [12:0] front_left_steer;
        logic [12:0] rear_left_steer;
        logic [12:0] front_right_steer;
        logic [12:0] rear_right_steer;
    } t_res;

    // reduced angle: theta in [-90,90] degrees and a flag to negate the result
    typedef struct packed {
        logic               neg;
        logic signed [12:0] theta;
    } t_ang;

    // arctan(2^-i) in q.16 degrees
    function automatic logic [ZW-1:0] atan_q16(input int unsigned i);
        logic [ZW-1:0] r;
        case (i)
            0:       r = 27'd2949120;
            1:       r = 27'd1740967;
            2:       r = 27'd919879;
            3:       r = 27'd466945;
            4:       r = 27'd234379;
            5:       r = 27'd117304;
            6:       r = 27'd58666;
            7:       r = 27'd29335;
            8:       r = 27'd14668;
            9:       r = 27'd7334;
            10:      r = 27'd3667;
            11:      r = 27'd1833;
            12:      r = 27'd917;
            13:      r = 27'd458;
            14:      r = 27'd229;
            15:      r = 27'd115;
            16:      r = 27'd57;
            17:      r = 27'd29;
            18:      r = 27'd14;
            19:      r = 27'd7;
            20:      r = 27'd4;
            21:      r = 27'd2;
            22:      r = 27'd1;
            default: r = 27'd0;
        endcase
        return r;
    endfunction

    // fold a 13-bit angle into [0,360)
    function automatic logic [12:0] mod_turn(input logic [12:0] a);
        return (a >= FULL_TURN) ? a - FULL_TURN : a;
    endfunction

    // angle in [0,360) to [-90,90] with a negate flag
    function automatic t_ang reduce_turn(input logic [12:0] t);
        logic signed [13:0] s;
        t_ang               r;
        s = (t >= HALF_TURN) ? $signed({1'b0, t}) - 14'sd5760 : $signed({1'b0, t});
        r.neg = 1'b0;
        if (s > 14'sd1440) begin
            s     = s - 14'sd2880;
            r.neg = 1'b1;
        end else if (s < -14'sd1440) begin
            s     = s + 14'sd2880;
            r.neg = 1'b1;
        end
        r.theta = s[12:0];
        return r;
    endfunction

endpackage

// ----- src/swk_cmd_if.sv -----
// swk_cmd_if: command channel, valid/ready with one t_cmd payload
// depends on swk_pkg
interface swk_cmd_if;
    logic          valid;
    logic          ready;
    swk_pkg::t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/swk_res_if.sv -----
// swk_res_if: result channel, valid/ready with one t_res payload
// depends on swk_pkg
interface swk_res_if;
    logic          valid;
    logic          ready;
    swk_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/swk_cordic.sv -----
// swk_cordic: fully pipelined cordic, one register stage per iteration
// rotation or vectoring mode; depends on swk_pkg for the arctan table
module swk_cordic #(
    parameter int STAGES = swk_pkg::CORDIC_STAGES_DEF,
    parameter int XW     = 33,
    parameter bit VECTOR = 1'b0
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [XW-1:0]         i_x,
    input  logic signed [XW-1:0]         i_y,
    input  logic signed [swk_pkg::ZW-1:0] i_z,
    output logic signed [XW-1:0]         o_x,
    output logic signed [XW-1:0]         o_y,
    output logic signed [swk_pkg::ZW-1:0] o_z
);

    logic signed [XW-1:0]          r_x [STAGES];
    logic signed [XW-1:0]          r_y [STAGES];
    logic signed [swk_pkg::ZW-1:0] r_z [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic signed [swk_pkg::ZW-1:0] ATAN = signed'(swk_pkg::atan_q16(k));
        logic signed [XW-1:0]          a_x, a_y, n_x, n_y;
        logic signed [swk_pkg::ZW-1:0] a_z, n_z;
        logic                          dir;

        if (k == 0) begin : g_first
            assign a_x = i_x;
            assign a_y = i_y;
            assign a_z = i_z;
        end else begin : g_next
            assign a_x = r_x[k-1];
            assign a_y = r_y[k-1];
            assign a_z = r_z[k-1];
        end

        // rotate towards z = 0, or towards y = 0 when vectoring
        assign dir = VECTOR ? (a_y < 0) : (a_z >= 0);

        always_comb begin
            if (dir) begin
                n_x = a_x - (a_y >>> k);
                n_y = a_y + (a_x >>> k);
                n_z = a_z - ATAN;
            end else begin
                n_x = a_x + (a_y >>> k);
                n_y = a_y - (a_x >>> k);
                n_z = a_z + ATAN;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k] <= n_x;
                r_y[k] <= n_y;
                r_z[k] <= n_z;
            end
        end
    end

    assign o_x = r_x[STAGES-1];
    assign o_y = r_y[STAGES-1];
    assign o_z = r_z[STAGES-1];

endmodule

// ----- src/swerve_wheel_kinematics_top.sv -----
// swerve_wheel_kinematics_top: field-oriented four-wheel swerve inverse kinematics
// depends on swk_pkg, swk_cmd_if, swk_res_if and swk_cordic
//
// one command beat in, one result beat out with speed and steering angle for all four
// wheels. the block is a single pipeline of 2*CORDIC_STAGES+7 register stages: two
// stages of input capture and angle folding, a rotation cordic for the heading and
// for each wheel position, a stage applying the quadrant sign, a stage of
// multiplications, a stage that sums the wheel vector, a vectoring cordic per wheel,
// then magnitude scaling and final rounding into the output register. a new command
// beat is taken every cycle unless the output register is full and its result beat is
// not taken, so the sustained rate is one beat per clock. when the result beat is not
// taken the whole pipeline holds, nothing is lost or repeated. the configuration
// registers are written through i_cfg_we/i_cfg_idx/i_cfg_data and should only change
// while no command is in flight.
module swerve_wheel_kinematics_top #(
    parameter int CORDIC_STAGES = swk_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    swk_cmd_if.sink                       i_cmd,
    swk_res_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [swk_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                   i_cfg_data
);

    localparam int S   = CORDIC_STAGES;
    localparam int LAT = 2 * S + 7;
    localparam int RXW = 33;   // rotation cordic datapath
    localparam int VXW = 30;   // vectoring cordic datapath
    localparam int ZW  = swk_pkg::ZW;

    // ---------------------------------------------------------------- configuration
    logic [15:0] r_radius;
    logic [12:0] r_mount [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            for (int w = 0; w < 4; w++) r_mount[w] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                swk_pkg::CFG_RADIUS:   r_radius   <= i_cfg_data;
                swk_pkg::CFG_MOUNT_FL: r_mount[0] <= i_cfg_data[12:0];
                swk_pkg::CFG_MOUNT_RL: r_mount[1] <= i_cfg_data[12:0];
                swk_pkg::CFG_MOUNT_FR: r_mount[2] <= i_cfg_data[12:0];
                swk_pkg::CFG_MOUNT_RR: r_mount[3] <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- flow control
    // the pipeline advances whenever the output register is empty or being drained
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en          = !r_vld[LAT-1] || o_res.ready;
    // no command beat is taken while reset is held
    assign i_cmd.ready = en && i_rst_n;
    assign o_res.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_cmd.valid};
        end
    end

    // ---------------------------------------------------------------- stage a: capture
    logic [15:0]        r_a_speed;
    logic [12:0]        r_a_head;
    logic signed [15:0] r_a_rot;
    logic [12:0]        r_a_face;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_speed <= i_cmd.data.travel_speed;
            r_a_head  <= swk_pkg::mod_turn(i_cmd.data.travel_heading);
            r_a_rot   <= i_cmd.data.rotation_rate;
            r_a_face  <= swk_pkg::mod_turn(i_cmd.data.robot_facing);
        end
    end

    // ---------------------------------------------------------------- stage b: angle fold
    // lane 0 is the heading, lanes 1..4 the wheel positions relative to the facing
    swk_pkg::t_ang      n_b_ang [5];
    logic signed [32:0] n_b_rr;
    logic [15:0]        r_b_speed;
    logic signed [32:0] r_b_rr;
    logic [4:0]         r_b_neg;
    logic signed [ZW-1:0] r_b_z [5];

    always_comb begin
        logic signed [13:0] d;
        n_b_ang[0] = swk_pkg::reduce_turn(r_a_head);
        for (int w = 0; w < 4; w++) begin
            d = $signed({1'b0, swk_pkg::mod_turn(r_mount[w])}) - $signed({1'b0, r_a_face});
            if (d < 0) d = d + 14'sd5760;
            n_b_ang[w+1] = swk_pkg::reduce_turn(d[12:0]);
        end
        n_b_rr = r_a_rot * $signed({1'b0, r_radius});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_speed <= r_a_speed;
            r_b_rr    <= n_b_rr;
            for (int l = 0; l < 5; l++) begin
                r_b_neg[l] <= n_b_ang[l].neg;
                r_b_z[l]   <= {{2{n_b_ang[l].theta[12]}}, n_b_ang[l].theta, 12'd0};
            end
        end
    end

    // ---------------------------------------------------------------- rotation cordics
    logic signed [RXW-1:0] rc_x [5];
    logic signed [RXW-1:0] rc_y [5];
    logic signed [ZW-1:0]  rc_z [5];

    for (genvar l = 0; l < 5; l++) begin : g_rot
        swk_cordic #(
            .STAGES (S),
            .XW     (RXW),
            .VECTOR (1'b0)
        ) u_rot (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   ($signed({3'b000, swk_pkg::CORDIC_K})),
            .i_y   ('0),
            .i_z   (r_b_z[l]),
            .o_x   (rc_x[l]),
            .o_y   (rc_y[l]),
            .o_z   (rc_z[l])
        );
    end

    // side data riding alongside the rotation cordics
    logic [15:0]        r_rd_speed [S];
    logic signed [32:0] r_rd_rr    [S];
    logic [4:0]         r_rd_neg   [S];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd_speed[0] <= r_b_speed;
            r_rd_rr[0]    <= r_b_rr;
            r_rd_neg[0]   <= r_b_neg;
            for (int k = 1; k < S; k++) begin
                r_rd_speed[k] <= r_rd_speed[k-1];
                r_rd_rr[k]    <= r_rd_rr[k-1];
                r_rd_neg[k]   <= r_rd_neg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------- stage c: quadrant sign
    logic signed [RXW-1:0] r_c_cos [5];
    logic signed [RXW-1:0] r_c_sin [5];
    logic [15:0]           r_c_speed;
    logic signed [32:0]    r_c_rr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 5; l++) begin
                r_c_cos[l] <= r_rd_neg[S-1][l] ? -rc_x[l] : rc_x[l];
                r_c_sin[l] <= r_rd_neg[S-1][l] ? -rc_y[l] : rc_y[l];
            end
            r_c_speed <= r_rd_speed[S-1];
            r_c_rr    <= r_rd_rr[S-1];
        end
    end

    // ---------------------------------------------------------------- stage d: products
    logic signed [49:0] r_d_ps, r_d_pc;
    logic signed [65:0] r_d_pwc [4];
    logic signed [65:0] r_d_pws [4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_ps <= $signed({1'b0, r_c_speed}) * r_c_sin[0];
            r_d_pc <= $signed({1'b0, r_c_speed}) * r_c_cos[0];
            for (int w = 0; w < 4; w++) begin
                r_d_pwc[w] <= r_c_rr * r_c_cos[w+1];
                r_d_pws[w] <= r_c_rr * r_c_sin[w+1];
            end
        end
    end

    // ---------------------------------------------------------------- stage e: wheel vector
    logic signed [VXW-1:0] n_e_x [4];
    logic signed [VXW-1:0] n_e_y [4];
    logic signed [ZW-1:0]  n_e_z [4];
    logic [3:0]            n_e_zero;
    logic signed [VXW-1:0] r_e_x [4];
    logic signed [VXW-1:0] r_e_y [4];
    logic signed [ZW-1:0]  r_e_z [4];
    logic [3:0]            r_e_zero;

    always_comb begin
        logic signed [49:0]    ncx;
        logic signed [VXW-1:0] cx, cy, vx, vy;
        ncx = -r_d_ps;
        cx  = VXW'(ncx >>> 22);
        cy  = VXW'(r_d_pc >>> 22);
        for (int w = 0; w < 4; w++) begin
            vx = cx - VXW'(r_d_pwc[w] >>> 38);
            vy = cy + VXW'(r_d_pws[w] >>> 38);
            n_e_zero[w] = (vx == 0) && (vy == 0);
            // left half plane: mirror through the origin and preload 180 degrees
            if (vx < 0) begin
                n_e_x[w] = -vx;
                n_e_y[w] = -vy;
                n_e_z[w] = ZW'(swk_pkg::HALF_TURN_Z);
            end else begin
                n_e_x[w] = vx;
                n_e_y[w] = vy;
                n_e_z[w] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_x    <= n_e_x;
            r_e_y    <= n_e_y;
            r_e_z    <= n_e_z;
            r_e_zero <= n_e_zero;
        end
    end

    // ---------------------------------------------------------------- vectoring cordics
    logic signed [VXW-1:0] vc_x [4];
    logic signed [VXW-1:0] vc_y [4];
    logic signed [ZW-1:0]  vc_z [4];
    logic [3:0]            vc_y_msb;

    for (genvar w = 0; w < 4; w++) begin : g_vec
        swk_cordic #(
            .STAGES (S),
            .XW     (VXW),
            .VECTOR (1'b1)
        ) u_vec (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (r_e_x[w]),
            .i_y   (r_e_y[w]),
            .i_z   (r_e_z[w]),
            .o_x   (vc_x[w]),
            .o_y   (vc_y[w]),
            .o_z   (vc_z[w])
        );
        // residual y is not needed downstream
        assign vc_y_msb[w] = vc_y[w][VXW-1];
    end

    logic [3:0] r_vd_zero [S];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vd_zero[0] <= r_e_zero;
            for (int k = 1; k < S; k++) r_vd_zero[k] <= r_vd_zero[k-1];
        end
    end

    // ---------------------------------------------------------------- stage f: gain, rounding
    logic signed [60:0] r_f_mag [4];
    logic signed [14:0] r_f_st  [4];
    logic [3:0]         r_f_zero;

    always_ff @(posedge i_clk) begin
        logic signed [ZW-1:0] zr;
        if (en) begin
            for (int w = 0; w < 4; w++) begin
                zr = vc_z[w] + ZW'(2048);
                r_f_mag[w] <= vc_x[w] * $signed({1'b0, swk_pkg::CORDIC_K});
                r_f_st[w]  <= 15'(zr >>> 12) - 15'sd1440;
            end
            r_f_zero <= r_vd_zero[S-1] & ~(vc_y_msb & 4'b0000);
        end
    end

    // ---------------------------------------------------------------- stage g: output register
    logic [15:0] n_g_speed [4];
    logic [12:0] n_g_steer [4];
    logic [15:0] r_g_speed [4];
    logic [12:0] r_g_steer [4];

    always_comb begin
        logic signed [30:0] m;
        logic signed [22:0] q;
        logic signed [14:0] s;
        for (int w = 0; w < 4; w++) begin
            m = 31'(r_f_mag[w] >>> 30);
            q = 23'((m + 31'sd128) >>> 8);
            if (q < 0)                 n_g_speed[w] = '0;
            else if (q > 23'sd65535)   n_g_speed[w] = 16'hffff;
            else                       n_g_speed[w] = q[15:0];
            s = r_f_st[w];
            if (s < 0)                 s = s + 15'sd5760;
            else if (s >= 15'sd5760)   s = s - 15'sd5760;
            n_g_steer[w] = s[12:0];
            // zero vector: no speed, wheel parked at 270 degrees
            if (r_f_zero[w]) begin
                n_g_speed[w] = '0;
                n_g_steer[w] = swk_pkg::ZERO_STEER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_speed <= n_g_speed;
            r_g_steer <= n_g_steer;
        end
    end

    assign o_res.data.front_left_speed  = r_g_speed[0];
    assign o_res.data.rear_left_speed   = r_g_speed[1];
    assign o_res.data.front_right_speed = r_g_speed[2];
    assign o_res.data.rear_right_speed  = r_g_speed[3];
    assign o_res.data.front_left_steer  = r_g_steer[0];
    assign o_res.data.rear_left_steer   = r_g_steer[1];
    assign o_res.data.front_right_steer = r_g_steer[2];
    assign o_res.data.rear_right_steer  = r_g_steer[3];

    // ---------------------------------------------------------------- assertions
    // a stalled output freezes every stage's valid bit
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-1] && !o_res.ready) |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");

    // an accepted command beat occupies the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> r_vld[0])
        else $error("accepted beat did not enter pipeline");

    // steering angles always land in [0,360)
    a_steer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.front_left_steer < swk_pkg::FULL_TURN) &&
                        (o_res.data.rear_left_steer < swk_pkg::FULL_TURN) &&
                        (o_res.data.front_right_steer < swk_pkg::FULL_TURN) &&
                        (o_res.data.rear_right_steer < swk_pkg::FULL_TURN))
        else $error("steering angle out of range");

endmodule
